// ===== src/at_command_line_parser_assert.svh =====
// ----------------------------------------------------------------------------
// at_command_line_parser_assert.svh
// Assertion macros used by the command line parser read-out sequencer.
// ----------------------------------------------------------------------------
`ifndef AT_COMMAND_LINE_PARSER_ASSERT_SVH
`define AT_COMMAND_LINE_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF
// checked property on clk, held off while in reset
`define ATCP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("atcp assertion failed");
// checked property on clk, also during reset
`define ATCP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("atcp assertion failed");
`else
`define ATCP_ASSERT(lbl, prop)
`define ATCP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== src/atcp_pkg.sv =====
// ----------------------------------------------------------------------------
// atcp_pkg
// Character codes, result codes and shared types of the command line parser.
// ----------------------------------------------------------------------------
package atcp_pkg;

    // characters of the command syntax
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_QUOTE = 8'h22;

    // reset value of the delimiter register (carriage return)
    localparam logic [7:0] DELIM_RESET = 8'h0D;

    // register byte offsets
    localparam logic [2:0] REG_DELIM = 3'd0;

    // parser states
    localparam logic [3:0] ST_START = 4'd0;
    localparam logic [3:0] ST_A     = 4'd1;
    localparam logic [3:0] ST_T     = 4'd2;
    localparam logic [3:0] ST_PLUS  = 4'd3;
    localparam logic [3:0] ST_QUERY = 4'd4;
    localparam logic [3:0] ST_EQ    = 4'd5;
    localparam logic [3:0] ST_TEST  = 4'd6;
    localparam logic [3:0] ST_SET   = 4'd7;
    localparam logic [3:0] ST_QUOTE = 4'd8;
    localparam logic [3:0] ST_SKIP  = 4'd9;

    // record types
    localparam logic [1:0] TY_NONE  = 2'd0;
    localparam logic [1:0] TY_QUERY = 2'd1;
    localparam logic [1:0] TY_TEST  = 2'd2;
    localparam logic [1:0] TY_SET   = 2'd3;

    // result kinds
    localparam logic [2:0] RK_HEADER = 3'd0;
    localparam logic [2:0] RK_NAME   = 3'd1;
    localparam logic [2:0] RK_PARAM  = 3'd2;
    localparam logic [2:0] RK_OK     = 3'd3;
    localparam logic [2:0] RK_ERROR  = 3'd4;

    // what the parser hands to the read-out sequencer for one character
    typedef struct packed {
        logic       start;    // character transfer taken this cycle
        logic       done;     // a command record finished
        logic [1:0] rtype;    // record type of the finished command
        logic       eol;      // line ends with this character
        logic       line_ok;  // character decodes back to the start state
    } rec_start_t;

endpackage

// ===== src/atcp_parse.sv =====
// ----------------------------------------------------------------------------
// atcp_parse
// Character decoder: parse state, buffer fill counts and the name and
// parameter buffers (synchronous memories, one read port each).
// ----------------------------------------------------------------------------
module atcp_parse #(
    parameter int NAME_CAP  = 15,
    parameter int PARAM_CAP = 31,
    parameter int NCW = $clog2(NAME_CAP + 1),
    parameter int PCW = $clog2(PARAM_CAP + 1),
    parameter int NAW = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1,
    parameter int PAW = (PARAM_CAP > 1) ? $clog2(PARAM_CAP) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  logic [7:0]              byte_value,
    input  logic                    end_of_line,
    input  logic [7:0]              delimiter,
    input  logic [NAW-1:0]          name_raddr,
    input  logic [PAW-1:0]          param_raddr,
    output logic [7:0]              name_rdata,
    output logic [7:0]              param_rdata,
    output logic [NCW-1:0]          name_count,
    output logic [PCW-1:0]          param_count,
    output atcp_pkg::rec_start_t    rec
);

    logic [3:0]     pst_reg, pst_next;
    logic [NCW-1:0] ncnt_reg, ncnt_next;
    logic [PCW-1:0] pcnt_reg, pcnt_next;

    logic [7:0] name_mem [NAME_CAP];
    logic [7:0] param_mem [PARAM_CAP];
    logic [7:0] name_rd_reg;
    logic [7:0] param_rd_reg;

    logic [3:0] nxt;
    logic       put_name;
    logic       put_param;
    logic       done;
    logic [1:0] rtype;
    logic       is_letter;
    logic       is_quote;
    logic       is_end;
    logic [3:0] end_state;
    logic       name_wr;
    logic       param_wr;

    // character classes
    assign is_letter = (byte_value >= atcp_pkg::CH_A) && (byte_value <= atcp_pkg::CH_Z);
    assign is_quote  = (byte_value == atcp_pkg::CH_QUOTE);
    assign is_end    = (byte_value == atcp_pkg::CH_SEMI) || (byte_value == delimiter);
    // ';' chains the next command at '+', the delimiter goes back to start
    assign end_state = (byte_value == atcp_pkg::CH_SEMI) ? atcp_pkg::ST_T : atcp_pkg::ST_START;

    // next state decode
    always_comb
    begin
        nxt       = atcp_pkg::ST_SKIP;
        put_name  = 1'b0;
        put_param = 1'b0;
        done      = 1'b0;
        rtype     = atcp_pkg::TY_NONE;
        case (pst_reg)
            atcp_pkg::ST_START:
            begin
                nxt = (byte_value == atcp_pkg::CH_A) ? atcp_pkg::ST_A : atcp_pkg::ST_SKIP;
            end
            atcp_pkg::ST_A:
            begin
                nxt = (byte_value == atcp_pkg::CH_T) ? atcp_pkg::ST_T : atcp_pkg::ST_SKIP;
            end
            atcp_pkg::ST_T:
            begin
                nxt = (byte_value == atcp_pkg::CH_PLUS) ? atcp_pkg::ST_PLUS
                                                        : atcp_pkg::ST_SKIP;
            end
            atcp_pkg::ST_PLUS:
            begin
                if (is_letter)
                begin
                    put_name = 1'b1;
                    nxt      = atcp_pkg::ST_PLUS;
                end
                else if (byte_value == atcp_pkg::CH_EQ)
                begin
                    nxt = atcp_pkg::ST_EQ;
                end
                else if (byte_value == atcp_pkg::CH_QMARK)
                begin
                    nxt = atcp_pkg::ST_QUERY;
                end
                else if (is_end)
                begin
                    nxt  = end_state;
                    done = 1'b1;
                end
            end
            atcp_pkg::ST_QUERY:
            begin
                if (is_end)
                begin
                    nxt   = end_state;
                    done  = 1'b1;
                    rtype = atcp_pkg::TY_QUERY;
                end
            end
            atcp_pkg::ST_EQ:
            begin
                if (byte_value == atcp_pkg::CH_QMARK)
                begin
                    nxt = atcp_pkg::ST_TEST;
                end
                else
                begin
                    put_param = 1'b1;
                    nxt       = is_quote ? atcp_pkg::ST_QUOTE : atcp_pkg::ST_SET;
                end
            end
            atcp_pkg::ST_TEST:
            begin
                if (is_end)
                begin
                    nxt   = end_state;
                    done  = 1'b1;
                    rtype = atcp_pkg::TY_TEST;
                end
            end
            atcp_pkg::ST_SET:
            begin
                if (is_end)
                begin
                    nxt   = end_state;
                    done  = 1'b1;
                    rtype = atcp_pkg::TY_SET;
                end
                else
                begin
                    put_param = 1'b1;
                    nxt       = is_quote ? atcp_pkg::ST_QUOTE : atcp_pkg::ST_SET;
                end
            end
            atcp_pkg::ST_QUOTE:
            begin
                put_param = 1'b1;
                nxt       = is_quote ? atcp_pkg::ST_SET : atcp_pkg::ST_QUOTE;
            end
            default:
            begin
                nxt = atcp_pkg::ST_SKIP;
            end
        endcase
    end

    // buffer writes, full buffers drop the character
    assign name_wr  = accept && put_name && (ncnt_reg < NCW'(NAME_CAP));
    assign param_wr = accept && put_param && (pcnt_reg < PCW'(PARAM_CAP));

    // state and count update
    always_comb
    begin
        pst_next  = pst_reg;
        ncnt_next = ncnt_reg;
        pcnt_next = pcnt_reg;
        if (accept)
        begin
            pst_next = end_of_line ? atcp_pkg::ST_START : nxt;
            if (done || end_of_line)
            begin
                ncnt_next = '0;
                pcnt_next = '0;
            end
            else
            begin
                if (name_wr)
                begin
                    ncnt_next = ncnt_reg + 1'b1;
                end
                if (param_wr)
                begin
                    pcnt_next = pcnt_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pst_reg  <= atcp_pkg::ST_START;
            ncnt_reg <= '0;
            pcnt_reg <= '0;
        end
        else
        begin
            pst_reg  <= pst_next;
            ncnt_reg <= ncnt_next;
            pcnt_reg <= pcnt_next;
        end
    end

    // name buffer
    always_ff @(posedge clk)
    begin
        if (name_wr)
        begin
            name_mem[ncnt_reg[NAW-1:0]] <= byte_value;
        end
        name_rd_reg <= name_mem[name_raddr];
    end

    // parameter buffer
    always_ff @(posedge clk)
    begin
        if (param_wr)
        begin
            param_mem[pcnt_reg[PAW-1:0]] <= byte_value;
        end
        param_rd_reg <= param_mem[param_raddr];
    end

    assign name_rdata  = name_rd_reg;
    assign param_rdata = param_rd_reg;
    // counts before this character are the lengths of a finished record
    assign name_count  = ncnt_reg;
    assign param_count = pcnt_reg;

    assign rec.start   = accept;
    assign rec.done    = done;
    assign rec.rtype   = rtype;
    assign rec.eol     = end_of_line;
    assign rec.line_ok = (nxt == atcp_pkg::ST_START);

endmodule

// ===== src/atcp_rdout.sv =====
// ----------------------------------------------------------------------------
// atcp_rdout
// Read-out sequencer: header, buffered name and parameter bytes, line status,
// all through one output register.
// ----------------------------------------------------------------------------
`include "at_command_line_parser_assert.svh"

module atcp_rdout #(
    parameter int NAME_CAP  = 15,
    parameter int PARAM_CAP = 31,
    parameter int NCW = $clog2(NAME_CAP + 1),
    parameter int PCW = $clog2(PARAM_CAP + 1),
    parameter int NAW = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1,
    parameter int PAW = (PARAM_CAP > 1) ? $clog2(PARAM_CAP) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  atcp_pkg::rec_start_t    rec,
    input  logic [NCW-1:0]          name_count,
    input  logic [PCW-1:0]          param_count,
    input  logic [7:0]              name_rdata,
    input  logic [7:0]              param_rdata,
    output logic [NAW-1:0]          name_raddr,
    output logic [PAW-1:0]          param_raddr,
    output logic                    idle,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              out_kind,
    output logic [1:0]              out_type,
    output logic [3:0]              out_nlen,
    output logic [4:0]              out_plen,
    output logic [7:0]              out_char,
    output logic                    out_last
);

    localparam int IW = (NCW > PCW) ? NCW : PCW;

    // read-out phases
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_HDR  = 3'd1;
    localparam logic [2:0] PH_NRD  = 3'd2;
    localparam logic [2:0] PH_NEM  = 3'd3;
    localparam logic [2:0] PH_PRD  = 3'd4;
    localparam logic [2:0] PH_PEM  = 3'd5;
    localparam logic [2:0] PH_STAT = 3'd6;

    logic [2:0]     phase_reg, phase_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic [NCW-1:0] nl_reg, nl_next;
    logic [PCW-1:0] pl_reg, pl_next;
    logic [1:0]     type_reg, type_next;
    logic           eol_reg, eol_next;
    logic           ok_reg, ok_next;

    logic           ov_reg, ov_next;
    logic [2:0]     okind_reg, okind_next;
    logic [1:0]     otype_reg, otype_next;
    logic [3:0]     onl_reg, onl_next;
    logic [4:0]     opl_reg, opl_next;
    logic [7:0]     ochar_reg, ochar_next;
    logic           olast_reg, olast_next;

    logic           out_free;
    logic           load;
    logic [IW:0]    idx_p1;
    logic [IW:0]    nl_ext;
    logic [IW:0]    pl_ext;
    logic           last_n;
    logic           last_p;
    logic [2:0]     after_param;
    logic [2:0]     after_name;
    logic [2:0]     after_hdr;
    logic [NCW+3:0] nl_wide;
    logic [PCW+4:0] pl_wide;

    assign out_free = !ov_reg || out_ready;
    assign idx_p1   = {1'b0, idx_reg} + 1'b1;
    assign nl_ext   = (IW + 1)'(nl_reg);
    assign pl_ext   = (IW + 1)'(pl_reg);
    assign last_n   = (idx_p1 == nl_ext);
    assign last_p   = (idx_p1 == pl_ext);
    assign nl_wide  = (NCW + 4)'(nl_reg);
    assign pl_wide  = (PCW + 5)'(pl_reg);

    // where each part of the record hands over
    assign after_param = eol_reg ? PH_STAT : PH_IDLE;
    assign after_name  = (pl_reg != '0) ? PH_PRD : after_param;
    assign after_hdr   = (nl_reg != '0) ? PH_NRD : after_name;

    // sequencer
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        nl_next    = nl_reg;
        pl_next    = pl_reg;
        type_next  = type_reg;
        eol_next   = eol_reg;
        ok_next    = ok_reg;
        load       = 1'b0;
        okind_next = okind_reg;
        otype_next = otype_reg;
        onl_next   = onl_reg;
        opl_next   = opl_reg;
        ochar_next = ochar_reg;
        olast_next = olast_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (rec.start)
                begin
                    nl_next   = name_count;
                    pl_next   = param_count;
                    type_next = rec.rtype;
                    eol_next  = rec.eol;
                    ok_next   = rec.line_ok;
                    idx_next  = '0;
                    if (rec.done)
                    begin
                        phase_next = PH_HDR;
                    end
                    else if (rec.eol)
                    begin
                        phase_next = PH_STAT;
                    end
                end
            end
            PH_HDR:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    okind_next = atcp_pkg::RK_HEADER;
                    otype_next = type_reg;
                    onl_next   = nl_wide[3:0];
                    opl_next   = pl_wide[4:0];
                    ochar_next = 8'd0;
                    olast_next = (nl_reg == '0) && (pl_reg == '0) && !eol_reg;
                    phase_next = after_hdr;
                end
            end
            PH_NRD:
            begin
                // buffer read is in flight
                phase_next = PH_NEM;
            end
            PH_NEM:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    okind_next = atcp_pkg::RK_NAME;
                    otype_next = atcp_pkg::TY_NONE;
                    onl_next   = 4'd0;
                    opl_next   = 5'd0;
                    ochar_next = name_rdata;
                    olast_next = last_n && (pl_reg == '0) && !eol_reg;
                    if (last_n)
                    begin
                        idx_next   = '0;
                        phase_next = after_name;
                    end
                    else
                    begin
                        idx_next   = idx_p1[IW-1:0];
                        phase_next = PH_NRD;
                    end
                end
            end
            PH_PRD:
            begin
                phase_next = PH_PEM;
            end
            PH_PEM:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    okind_next = atcp_pkg::RK_PARAM;
                    otype_next = atcp_pkg::TY_NONE;
                    onl_next   = 4'd0;
                    opl_next   = 5'd0;
                    ochar_next = param_rdata;
                    olast_next = last_p && !eol_reg;
                    if (last_p)
                    begin
                        idx_next   = '0;
                        phase_next = after_param;
                    end
                    else
                    begin
                        idx_next   = idx_p1[IW-1:0];
                        phase_next = PH_PRD;
                    end
                end
            end
            PH_STAT:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    okind_next = ok_reg ? atcp_pkg::RK_OK : atcp_pkg::RK_ERROR;
                    otype_next = atcp_pkg::TY_NONE;
                    onl_next   = 4'd0;
                    opl_next   = 5'd0;
                    ochar_next = 8'd0;
                    olast_next = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // output register valid
    always_comb
    begin
        if (load)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
        else
        begin
            ov_next = ov_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    // record snapshot and output payload
    always_ff @(posedge clk)
    begin
        nl_reg    <= nl_next;
        pl_reg    <= pl_next;
        type_reg  <= type_next;
        eol_reg   <= eol_next;
        ok_reg    <= ok_next;
        okind_reg <= okind_next;
        otype_reg <= otype_next;
        onl_reg   <= onl_next;
        opl_reg   <= opl_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    assign name_raddr  = idx_reg[NAW-1:0];
    assign param_raddr = idx_reg[PAW-1:0];
    assign idle        = (phase_reg == PH_IDLE);
    assign out_valid   = ov_reg;
    assign out_kind    = okind_reg;
    assign out_type    = otype_reg;
    assign out_nlen    = onl_reg;
    assign out_plen    = opl_reg;
    assign out_char    = ochar_reg;
    assign out_last    = olast_reg;

    // byte indexes stay inside the stored lengths
    `ATCP_ASSERT(a_name_idx, (phase_reg == PH_NEM) |-> (idx_p1 <= nl_ext))
    `ATCP_ASSERT(a_param_idx, (phase_reg == PH_PEM) |-> (idx_p1 <= pl_ext))
    // a finished command always starts with its header
    `ATCP_ASSERT(a_hdr_first, (rec.start && rec.done) |=> (phase_reg == PH_HDR))
    // a line status closes the run
    `ATCP_ASSERT(a_stat_last,
        (ov_reg && (okind_reg == atcp_pkg::RK_OK || okind_reg == atcp_pkg::RK_ERROR))
            |-> olast_reg)
    // out of reset the output register is empty
    `ATCP_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !ov_reg)

endmodule

// ===== src/at_command_line_parser.sv =====
// ----------------------------------------------------------------------------
// at_command_line_parser
// AT command line parser: one character per transfer in, command records
// (header, name bytes, parameter bytes) and a line status out.
//
// channel   direction  handshake           payload
// s_*       in         s_tvalid/s_tready   tdata byte_value, tlast end_of_line
// m_*       out        m_tvalid/m_tready   tuser result_kind, tdata record fields,
//                                          tlast last_of_run
// apb       in/out     psel/penable        delimiter at byte offset 0
//
// A character with no finished command and no line end starts no read-out.
// A finished command reads out its header, then each stored name and
// parameter byte, each through a buffer read step and an output load step.
// The line status follows at a line end. Input is held off during read-out.
// Output stalls hold the sequencer; the last result of a run may still wait
// in the output register while the next character is taken.
// Reset clears parse state, counts, output valid and the delimiter (to 13);
// the buffers need no clearing.
// ----------------------------------------------------------------------------
module at_command_line_parser #(
    parameter int NAME_CAP  = 15,
    parameter int PARAM_CAP = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    // character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_value
    input  logic        s_tlast,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [1:0] record_type, [5:2] name_length,
                                   // [10:6] param_length, [18:11] char_out, rest 0
    output logic [2:0]  m_tuser,   // [2:0] result_kind
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int NCW = $clog2(NAME_CAP + 1);
    localparam int PCW = $clog2(PARAM_CAP + 1);
    localparam int NAW = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1;
    localparam int PAW = (PARAM_CAP > 1) ? $clog2(PARAM_CAP) : 1;

    logic [7:0]           delim_reg, delim_next;
    logic                 accept;
    logic                 idle;
    atcp_pkg::rec_start_t rec;
    logic [NCW-1:0]       name_count;
    logic [PCW-1:0]       param_count;
    logic [7:0]           name_rdata;
    logic [7:0]           param_rdata;
    logic [NAW-1:0]       name_raddr;
    logic [PAW-1:0]       param_raddr;
    logic [1:0]           out_type;
    logic [3:0]           out_nlen;
    logic [4:0]           out_plen;
    logic [7:0]           out_char;
    logic                 reg_sel;

    // configuration register, byte offset within the word is ignored
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == atcp_pkg::REG_DELIM[2]);
    assign delim_next = (psel && penable && pwrite && reg_sel) ? pwdata[7:0] : delim_reg;
    assign prdata  = reg_sel ? {24'd0, delim_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= atcp_pkg::DELIM_RESET;
        end
        else
        begin
            delim_reg <= delim_next;
        end
    end

    // character transfer
    assign s_tready = idle;
    assign accept   = s_tvalid && idle;

    atcp_parse #(
        .NAME_CAP  (NAME_CAP),
        .PARAM_CAP (PARAM_CAP),
        .NCW       (NCW),
        .PCW       (PCW),
        .NAW       (NAW),
        .PAW       (PAW)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .byte_value  (s_tdata),
        .end_of_line (s_tlast),
        .delimiter   (delim_reg),
        .name_raddr  (name_raddr),
        .param_raddr (param_raddr),
        .name_rdata  (name_rdata),
        .param_rdata (param_rdata),
        .name_count  (name_count),
        .param_count (param_count),
        .rec         (rec)
    );

    atcp_rdout #(
        .NAME_CAP  (NAME_CAP),
        .PARAM_CAP (PARAM_CAP),
        .NCW       (NCW),
        .PCW       (PCW),
        .NAW       (NAW),
        .PAW       (PAW)
    ) u_rdout (
        .clk         (clk),
        .rst_n       (rst_n),
        .rec         (rec),
        .name_count  (name_count),
        .param_count (param_count),
        .name_rdata  (name_rdata),
        .param_rdata (param_rdata),
        .name_raddr  (name_raddr),
        .param_raddr (param_raddr),
        .idle        (idle),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_kind    (m_tuser),
        .out_type    (out_type),
        .out_nlen    (out_nlen),
        .out_plen    (out_plen),
        .out_char    (out_char),
        .out_last    (m_tlast)
    );

    // result payload packing
    assign m_tdata = {5'd0, out_char, out_plen, out_nlen, out_type};

endmodule
